// ===== rtl/core/block_pool_allocator_top_macros.svh =====
// ----------------------------------------------------------------------------
// block_pool_allocator_top_macros.svh
// Assertion shorthands for the block pool allocator.
// ----------------------------------------------------------------------------
`ifndef BLOCK_POOL_ALLOCATOR_TOP_MACROS_SVH
`define BLOCK_POOL_ALLOCATOR_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define BPA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define BPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/bpa_pkg.sv =====
// ----------------------------------------------------------------------------
// bpa_pkg
// Types and constants shared by the block pool allocator modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bpa_pkg;

  localparam int MAX_BLOCKS = 64;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);

  localparam int BSIZE_W = 13;
  localparam int BUSE_W  = 7;
  localparam int REQ_W   = 16;
  localparam int OFF_W   = 18;
  localparam int START_W = 6;

  localparam logic [BSIZE_W-1:0] BSIZE_RST = 13'd128;
  localparam logic [BUSE_W-1:0]  BUSE_RST  = 7'd8;

  // Register index within the configuration space (paddr[2])
  localparam logic REG_BLOCK_SIZE    = 1'b0;
  localparam logic REG_BLOCKS_IN_USE = 1'b1;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    ST_ALLOC    = 3'd0,
    ST_NOT_MULT = 3'd1,
    ST_INSUFF   = 3'd2,
    ST_FREED    = 3'd3,
    ST_BAD_IDX  = 3'd4
  } status_t;

  typedef struct packed {
    opcode_t              opcode;
    logic [REQ_W-1:0]     request_bytes;
    logic [START_W-1:0]   free_index;
  } req_t;

  typedef struct packed {
    status_t              status;
    logic [START_W-1:0]   start_block;
    logic [OFF_W-1:0]     byte_offset;
  } rsp_t;

  typedef struct packed {
    logic                 done;
    logic [REQ_W-1:0]     quotient;
    logic                 rem_zero;
  } div_res_t;

endpackage

// ===== rtl/core/block_pool_allocator_top.sv =====
// ----------------------------------------------------------------------------
// block_pool_allocator_top: fixed-size block pool allocator
// Free, or allocate with a zero block size: the request goes to S_DONE, which
// loads the result register once the output is free. Allocate: S_DIV through
// the 16-step divider, then S_SCAN for a free run and S_CLAIM of its blocks.
// Next request is taken the cycle after the result loads; one item at a time.
// Reset (sync) sets all blocks free.
`timescale 1ns / 1ps

`include "block_pool_allocator_top_macros.svh"

module block_pool_allocator_top
  import bpa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        req_valid,
  output logic        req_ready,
  input  req_t        req,
  // response channel
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output rsp_t        rsp,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_SCAN,
    S_CLAIM,
    S_DONE
  } state_t;

  state_t                 state;
  logic [BSIZE_W-1:0]     block_size;
  logic [BUSE_W-1:0]      blocks_in_use;
  logic [MAX_BLOCKS-1:0]  free_map;
  logic [CNT_W-1:0]       need_r;
  logic [CNT_W-1:0]       scan_i;
  logic [CNT_W-1:0]       run;
  logic [IDX_W-1:0]       start_r;
  logic [IDX_W-1:0]       end_r;
  logic [IDX_W-1:0]       ptr;
  status_t                status_r;

  logic                   req_xfer;
  logic                   div_start;
  div_res_t               div_res;
  logic [CNT_W-1:0]       count_eff;
  logic                   scan_bit;
  logic [CNT_W-1:0]       run_next;
  logic                   scan_hit;
  logic [CNT_W-1:0]       scan_start;
  logic [IDX_W+BSIZE_W-1:0] product;
  logic                   rsp_load;
  logic                   cfg_wr;

  assign req_ready = (state == S_IDLE);
  assign req_xfer  = req_valid && req_ready;
  assign div_start = req_xfer && (req.opcode == OP_ALLOC) && (block_size != '0);

  bpa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (req.request_bytes),
    .divisor  (block_size),
    .res      (div_res)
  );

  always_comb begin
    count_eff  = (blocks_in_use > BUSE_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
                                                        : CNT_W'(blocks_in_use);
    scan_bit   = free_map[scan_i[IDX_W-1:0]];
    run_next   = scan_bit ? run + 1'b1 : '0;
    scan_hit   = (run_next == need_r);
    scan_start = scan_i + 1'b1 - need_r;
    product    = {{BSIZE_W{1'b0}}, start_r} * {{IDX_W{1'b0}}, block_size};
    rsp_load   = (state == S_DONE) && (!rsp_valid || rsp_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      free_map  <= '1;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_xfer) begin
            start_r <= '0;
            if (req.opcode == OP_FREE) begin
              if (CNT_W'(req.free_index) < count_eff) begin
                free_map[req.free_index] <= 1'b1;
                status_r <= ST_FREED;
              end else begin
                status_r <= ST_BAD_IDX;
              end
              state <= S_DONE;
            end else if (block_size == '0) begin
              status_r <= ST_NOT_MULT;
              state    <= S_DONE;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_res.done) begin
            scan_i <= '0;
            run    <= '0;
            need_r <= div_res.quotient[CNT_W-1:0];
            if (!div_res.rem_zero) begin
              status_r <= ST_NOT_MULT;
              state    <= S_DONE;
            end else if (div_res.quotient == '0 ||
                         div_res.quotient > REQ_W'(count_eff)) begin
              status_r <= ST_INSUFF;
              state    <= S_DONE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          run    <= run_next;
          scan_i <= scan_i + 1'b1;
          if (scan_hit) begin
            start_r <= scan_start[IDX_W-1:0];
            ptr     <= scan_start[IDX_W-1:0];
            end_r   <= scan_i[IDX_W-1:0];
            state   <= S_CLAIM;
          end else if (scan_i == count_eff - 1'b1) begin
            status_r <= ST_INSUFF;
            state    <= S_DONE;
          end
        end
        S_CLAIM: begin
          // drop one block of the run per cycle
          free_map[ptr] <= 1'b0;
          ptr <= ptr + 1'b1;
          if (ptr == end_r) begin
            status_r <= ST_ALLOC;
            state    <= S_DONE;
          end
        end
        S_DONE: begin
          // hold until the output register is free
          if (rsp_load) begin
            rsp.status      <= status_r;
            rsp.start_block <= START_W'(start_r);
            rsp.byte_offset <= OFF_W'(product);
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_size    <= BSIZE_RST;
      blocks_in_use <= BUSE_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_BLOCK_SIZE) begin
        block_size <= pwdata[BSIZE_W-1:0];
      end else begin
        blocks_in_use <= pwdata[BUSE_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_BLOCKS_IN_USE) begin
      prdata = {{(32-BUSE_W){1'b0}}, blocks_in_use};
    end else begin
      prdata = {{(32-BSIZE_W){1'b0}}, block_size};
    end
  end

  `BPA_ASSERT_NEXT(a_xfer_leaves_idle, req_xfer, state != S_IDLE, "transfer did not start work")
  `BPA_ASSERT_SAME(a_scan_need_ok, state == S_SCAN, need_r != '0 && need_r <= count_eff, "scan with bad run length")
  `BPA_ASSERT_SAME(a_claim_in_run, state == S_CLAIM, ptr >= start_r && ptr <= end_r, "claim pointer left the run")
  `BPA_ASSERT_NEXT(a_alloc_claimed, rsp_load && status_r == ST_ALLOC, !free_map[rsp.start_block], "allocated block still free")

endmodule

// ===== rtl/core/bpa_div.sv =====
// ----------------------------------------------------------------------------
// bpa_div
// Restoring divider, one quotient bit per cycle, for request size / block size.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpa_div
  import bpa_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [REQ_W-1:0]   dividend,
  input  logic [BSIZE_W-1:0] divisor,
  output div_res_t           res
);

  localparam int STEP_W = $clog2(REQ_W);

  logic                 busy;
  logic                 done;
  logic [STEP_W-1:0]    step;
  logic [BSIZE_W-1:0]   rem;
  logic [REQ_W-1:0]     quo;
  logic [BSIZE_W-1:0]   dvsr;

  logic [BSIZE_W:0]     trial;
  logic [BSIZE_W+1:0]   diff;
  logic                 fits;
  logic [BSIZE_W-1:0]   rem_next;

  always_comb begin
    trial    = {rem, quo[REQ_W-1]};
    diff     = {1'b0, trial} - {2'b00, dvsr};
    fits     = !diff[BSIZE_W+1];
    // remainder stays below the divisor, so it fits the divisor width
    rem_next = fits ? diff[BSIZE_W-1:0] : trial[BSIZE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        rem  <= '0;
        quo  <= dividend;
        dvsr <= divisor;
      end else if (busy) begin
        rem  <= rem_next;
        quo  <= {quo[REQ_W-2:0], fits};
        step <= step + 1'b1;
        if (step == STEP_W'(REQ_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign res.done     = done;
  assign res.quotient = quo;
  assign res.rem_zero = (rem == '0);

endmodule
